// ===== sv/mgt_pkg.sv =====
// ============================================================================
// mgt_pkg
// Shared codes, widths and types for the MIDI gate/trigger clock divider.
// ============================================================================
package mgt_pkg;

    // Build defaults
    localparam int DEF_GATES         = 8;
    localparam int DEF_NOCLOCK_TICKS = 1000;

    // Fixed widths
    localparam int LEVELS_W  = 8;
    localparam int SILENCE_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SETTING    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_OUT_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_OUT_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GATE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_LIMIT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN        = 3'd6;

    // USB-MIDI code index numbers
    localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
    localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
    localparam logic [3:0] CIN_CTRL     = 4'hB;
    localparam logic [3:0] CIN_SINGLE   = 4'hF;

    // Status bytes
    localparam logic [7:0] ST_CLOCK    = 8'hF8;
    localparam logic [7:0] ST_START    = 8'hFA;
    localparam logic [7:0] ST_CONTINUE = 8'hFB;
    localparam logic [7:0] ST_STOP     = 8'hFC;

    // Controller numbers
    localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [6:0] CC_CLOCK_RELOAD  = 7'd126;

    localparam logic [7:0] NOTE_BASE = 8'd60;

    // Reset values of the registers
    localparam logic [6:0] RST_CLOCK_SETTING = 7'd1;
    localparam logic [7:0] RST_GATE_LIMIT    = 8'd8;
    localparam logic [7:0] RST_PULSE_LEN     = 8'd10;

    // Per-word command to the gate bank
    typedef struct packed {
        logic step;     // word retires this cycle
        logic set_en;   // note on/off
        logic set_on;   // on (note on with nonzero velocity)
        logic clear;    // all-gates-off controller
        logic tick;     // time tick
    } gate_cmd_t;

    // Gate-related settings
    typedef struct packed {
        logic       gate_en;
        logic       trig_mode;
        logic [7:0] first_gate;
        logic [7:0] gate_limit;
        logic [7:0] pulse_len;
    } gate_cfg_t;

endpackage

// ===== sv/mgt_gate_bank.sv =====
// ============================================================================
// mgt_gate_bank
// Note gate outputs with per-gate trigger countdowns.
// ============================================================================
module mgt_gate_bank import mgt_pkg::*; #(
    parameter int GATES = DEF_GATES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  gate_cmd_t        cmd,
    input  gate_cfg_t        cfg,
    input  logic [7:0]       gate_idx,
    output logic [GATES-1:0] gate_next
);

    localparam logic [7:0] GATES_CAP = 8'(GATES);

    logic [7:0] top_gate;
    assign top_gate = (cfg.gate_limit < GATES_CAP) ? cfg.gate_limit : GATES_CAP;

    genvar g;
    generate
        for (g = 0; g < GATES; g++) begin : gen_gate
            logic       out_reg, out_next;
            logic [7:0] cnt_reg, cnt_next;
            logic       in_range;

            assign in_range = (8'(g) >= cfg.first_gate) && (8'(g) < top_gate);

            always_comb begin
                out_next = out_reg;
                cnt_next = cnt_reg;
                if (cmd.set_en && cfg.gate_en && in_range && gate_idx == 8'(g)) begin
                    if (cmd.set_on) begin
                        out_next = 1'b1;
                        cnt_next = cfg.pulse_len;
                    end else if (!cfg.trig_mode) begin
                        out_next = 1'b0;
                        cnt_next = 8'd0;
                    end
                end
                if (cmd.clear && cfg.gate_en && in_range) begin
                    out_next = 1'b0;
                    cnt_next = 8'd0;
                end
                if (cmd.tick && cfg.trig_mode && in_range && cnt_reg != 8'd0) begin
                    cnt_next = cnt_reg - 8'd1;
                    if (cnt_reg == 8'd1) out_next = 1'b0;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    out_reg <= 1'b0;
                    cnt_reg <= 8'd0;
                end else if (cmd.step) begin
                    out_reg <= out_next;
                    cnt_reg <= cnt_next;
                end
            end

            assign gate_next[g] = out_next;
        end
    endgenerate

endmodule

// ===== sv/midi_gate_trigger_clock_divider_top.sv =====
// ============================================================================
// midi_gate_trigger_clock_divider_top
// USB-MIDI to gate/trigger outputs with a divided, run-gated clock.
// ============================================================================
// Usage:
//   s_* channel takes one word per cycle while s_ready is high: a
//   USB-MIDI event packet (s_kind = 0) or a time tick (s_kind = 1). m_*
//   channel returns one word per input word: gate levels, clock level
//   and run level after that word has been applied.
//   The accepting edge loads the input register; the single-pass update
//   is then loaded into the result register once that register can advance.
//   Throughput: one word per cycle while m_ready is high, limited
//   otherwise only by the state update loop on the counters.
//   When m_ready is low the result word holds and one more input word
//   waits in the input register; s_ready drops only then.
//   Reset (aresetn low, synchronous) empties both registers, restores
//   the register defaults and resets all counters and outputs.
//   Configuration: cfg_we writes cfg_data into register cfg_index at
//   once; writes are expected only while the block is idle. Writing
//   clock_setting reloads the divide ratio and start/stop control.
// ============================================================================
module midi_gate_trigger_clock_divider_top import mgt_pkg::*; #(
    parameter int GATES         = DEF_GATES,
    parameter int NOCLOCK_TICKS = DEF_NOCLOCK_TICKS
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [3:0]           s_code_index,
    input  logic [7:0]           s_status_byte,
    input  logic [7:0]           s_data_one,
    input  logic [7:0]           s_data_two,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [LEVELS_W-1:0]  m_gate_levels,
    output logic                 m_clock_level,
    output logic                 m_run_level
);

    localparam logic [SILENCE_W-1:0] SILENCE_LOAD = SILENCE_W'(NOCLOCK_TICKS);

    // ---------------- configuration registers ----------------
    logic       clk_en_reg, gate_en_reg, trig_mode_reg;
    logic [7:0] first_gate_reg, gate_limit_reg, pulse_len_reg;

    // ---------------- clock state ----------------
    logic [5:0]           ratio_reg, ratio_next;
    logic                 ssc_reg, ssc_next;
    logic                 running_reg, running_next;
    logic [5:0]           ccnt_reg, ccnt_next;
    logic [7:0]           pulse_reg, pulse_next;
    logic [SILENCE_W-1:0] silence_reg, silence_next;
    logic                 clk_out_reg, clk_out_next;
    logic                 run_out_reg, run_out_next;

    // ---------------- input register ----------------
    logic       in_valid_reg;
    logic       kind_reg;
    logic [3:0] cin_reg;
    logic [7:0] st_reg, d1_reg, d2_reg;

    // ---------------- result register ----------------
    logic                out_valid_reg;
    logic [LEVELS_W-1:0] levels_reg;
    logic                clock_lvl_reg, run_lvl_reg;

    logic advance, step;
    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            cin_reg  <= s_code_index;
            st_reg   <= s_status_byte;
            d1_reg   <= s_data_one;
            d2_reg   <= s_data_two;
        end
    end

    // ---------------- decode ----------------
    logic       pkt, single, low_zero, cc_word;
    logic [6:0] note;
    assign pkt      = !kind_reg;
    assign single   = pkt && cin_reg == CIN_SINGLE;
    assign low_zero = pkt && st_reg[3:0] == 4'h0;
    assign note     = d1_reg[6:0];
    assign cc_word  = low_zero && cin_reg == CIN_CTRL;

    gate_cmd_t  gcmd;
    gate_cfg_t  gcfg;
    logic [GATES-1:0] gate_next;

    assign gcmd.step   = step;
    assign gcmd.set_en = low_zero && (cin_reg == CIN_NOTE_OFF || cin_reg == CIN_NOTE_ON);
    assign gcmd.set_on = cin_reg == CIN_NOTE_ON && d2_reg[6:0] != 7'd0;
    assign gcmd.clear  = cc_word && note != CC_CLOCK_RELOAD &&
                         (note == CC_ALL_SOUND_OFF || note == CC_ALL_NOTES_OFF);
    assign gcmd.tick   = kind_reg;

    assign gcfg.gate_en    = gate_en_reg;
    assign gcfg.trig_mode  = trig_mode_reg;
    assign gcfg.first_gate = first_gate_reg;
    assign gcfg.gate_limit = gate_limit_reg;
    assign gcfg.pulse_len  = pulse_len_reg;

    mgt_gate_bank #(
        .GATES (GATES)
    ) u_gates (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (gcmd),
        .cfg       (gcfg),
        .gate_idx  ({1'b0, note} - NOTE_BASE),
        .gate_next (gate_next)
    );

    // ---------------- clock / run update ----------------
    always_comb begin
        ratio_next   = ratio_reg;
        ssc_next     = ssc_reg;
        running_next = running_reg;
        ccnt_next    = ccnt_reg;
        pulse_next   = pulse_reg;
        silence_next = silence_reg;
        clk_out_next = clk_out_reg;
        run_out_next = run_out_reg;

        if (kind_reg) begin
            if (clk_en_reg) begin
                if (pulse_reg != 8'd0) begin
                    pulse_next = pulse_reg - 8'd1;
                    if (pulse_reg == 8'd1) clk_out_next = 1'b0;
                end
                if (silence_reg != '0) begin
                    silence_next = silence_reg - SILENCE_W'(1);
                    if (silence_reg == SILENCE_W'(1)) ccnt_next = 6'd1;
                end
            end
        end else begin
            if (single) begin
                case (st_reg)
                    ST_CLOCK: begin
                        silence_next = SILENCE_LOAD;
                        if (running_reg && clk_en_reg && ccnt_reg != 6'd0) begin
                            ccnt_next = ccnt_reg - 6'd1;
                            if (ccnt_reg == 6'd1) begin
                                ccnt_next    = ratio_reg;
                                clk_out_next = 1'b1;
                                pulse_next   = pulse_len_reg;
                            end
                        end
                    end
                    ST_START, ST_CONTINUE: begin
                        if (clk_en_reg) begin
                            run_out_next = 1'b1;
                            if (ssc_reg) begin
                                running_next = 1'b1;
                                ccnt_next    = 6'd1;
                            end
                        end
                    end
                    ST_STOP: begin
                        if (clk_en_reg) begin
                            run_out_next = 1'b0;
                            if (ssc_reg) running_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            // clock reload controller; value 0 ignored, bit 7 dropped
            if (cc_word && note == CC_CLOCK_RELOAD && d2_reg != 8'd0) begin
                ratio_next   = d2_reg[5:0];
                ssc_next     = d2_reg[6];
                running_next = !d2_reg[6];
            end
        end
    end

    // Clock state: word updates and the clock_setting reload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg   <= RST_CLOCK_SETTING[5:0];
            ssc_reg     <= RST_CLOCK_SETTING[6];
            running_reg <= !RST_CLOCK_SETTING[6];
            ccnt_reg    <= 6'd1;
            pulse_reg   <= 8'd0;
            silence_reg <= SILENCE_LOAD;
            clk_out_reg <= 1'b0;
            run_out_reg <= 1'b0;
        end else if (cfg_we && cfg_index == CFG_CLOCK_SETTING) begin
            ratio_reg   <= cfg_data[5:0];
            ssc_reg     <= cfg_data[6];
            running_reg <= !cfg_data[6];
        end else if (step) begin
            ratio_reg   <= ratio_next;
            ssc_reg     <= ssc_next;
            running_reg <= running_next;
            ccnt_reg    <= ccnt_next;
            pulse_reg   <= pulse_next;
            silence_reg <= silence_next;
            clk_out_reg <= clk_out_next;
            run_out_reg <= run_out_next;
        end
    end

    // Remaining configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_en_reg     <= 1'b1;
            gate_en_reg    <= 1'b1;
            trig_mode_reg  <= 1'b0;
            first_gate_reg <= 8'd0;
            gate_limit_reg <= RST_GATE_LIMIT;
            pulse_len_reg  <= RST_PULSE_LEN;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CLOCK_OUT_ENABLE: clk_en_reg     <= cfg_data[0];
                CFG_GATE_OUT_ENABLE:  gate_en_reg    <= cfg_data[0];
                CFG_TRIGGER_MODE:     trig_mode_reg  <= cfg_data[0];
                CFG_FIRST_GATE:       first_gate_reg <= cfg_data;
                CFG_GATE_LIMIT:       gate_limit_reg <= cfg_data;
                CFG_PULSE_LEN:        pulse_len_reg  <= cfg_data;
                default: ;  // clock_setting handled above; others ignored
            endcase
        end
    end

    // ---------------- result word ----------------
    logic [LEVELS_W-1:0] levels_next;
    genvar b;
    generate
        for (b = 0; b < LEVELS_W; b++) begin : gen_lvl
            if (b < GATES) begin : gen_on
                assign levels_next[b] = gate_next[b];
            end else begin : gen_off
                assign levels_next[b] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            levels_reg    <= levels_next;
            clock_lvl_reg <= clk_out_next;
            run_lvl_reg   <= run_out_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_gate_levels = levels_reg;
    assign m_clock_level = clock_lvl_reg;
    assign m_run_level   = run_lvl_reg;

endmodule

// ===== tb/midi_gate_trigger_clock_divider_top_tb.sv =====
// ============================================================================
// midi_gate_trigger_clock_divider_top_tb
// Self-checking bench: drives packet and tick words through the valid/ready
// input, predicts gate, clock and run levels for every word, and checks each
// result word in order under random sender gaps and receiver stalls.
// ============================================================================
module midi_gate_trigger_clock_divider_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgt_pkg::*;

    localparam int GATES         = DEF_GATES;
    localparam int NOCLOCK_TICKS = DEF_NOCLOCK_TICKS;

    // Channel-1 status bytes used to build well-formed packets
    localparam logic [7:0] ST_NOTE_OFF_CH1 = 8'h80;
    localparam logic [7:0] ST_NOTE_ON_CH1  = 8'h90;
    localparam logic [7:0] ST_CTRL_CH1     = 8'hB0;
    // Register index past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int SETTLE_CYCLES   = 6;       // margin after the last result
    localparam int WORDS_PER_PHASE = 32;
    localparam int PHASES          = 7;
    localparam int LIMIT_NS        = 4_000_000;

    typedef struct packed {
        logic [LEVELS_W-1:0] gates;
        logic                clk;
        logic                run;
    } midi_levels_t;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic [3:0]           s_code_index;
    logic [7:0]           s_status_byte;
    logic [7:0]           s_data_one;
    logic [7:0]           s_data_two;
    logic                 m_valid;
    logic                 m_ready;
    logic [LEVELS_W-1:0]  m_gate_levels;
    logic                 m_clock_level;
    logic                 m_run_level;

    midi_gate_trigger_clock_divider_top #(
        .GATES         (GATES),
        .NOCLOCK_TICKS (NOCLOCK_TICKS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_code_index  (s_code_index),
        .s_status_byte (s_status_byte),
        .s_data_one    (s_data_one),
        .s_data_two    (s_data_two),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gate_levels (m_gate_levels),
        .m_clock_level (m_clock_level),
        .m_run_level   (m_run_level)
    );

    // ------------------------------------------------------------------------
    // Predictor state: register copies and the block's counters
    // ------------------------------------------------------------------------
    logic             set_clk_en;
    logic             set_gate_en;
    logic             set_trig_mode;
    logic [7:0]       set_first_gate;
    logic [7:0]       set_gate_limit;
    logic [7:0]       set_pulse_len;

    logic [5:0]       div_ratio;
    logic             ss_ctrl;
    logic             clk_running;
    logic [5:0]       clk_count;
    logic [7:0]       pulse_count;
    logic [15:0]      silence_count;
    logic             clk_out;
    logic             run_out;
    logic [GATES-1:0] gate_q;
    logic [7:0]       gate_count [GATES];

    midi_levels_t     levels_due [$];     // expected result words, oldest first

    int unsigned      fail_count      = 0;
    int unsigned      results_checked = 0;
    int unsigned      words_sent      = 0;
    int unsigned      tick_words      = 0;
    int unsigned      clock_words     = 0;
    int unsigned      note_words      = 0;
    int unsigned      reg_writes      = 0;
    int unsigned      rx_hold_req     = 0;  // receiver hold-off request, in cycles

    // Clock-setting reload: ratio and start/stop control, run state follows
    function automatic void load_clock(input logic [6:0] v);
        div_ratio   = v[5:0];
        ss_ctrl     = v[6];
        clk_running = !v[6];
    endfunction

    function automatic int unsigned gate_top();
        return (set_gate_limit < GATES) ? set_gate_limit : GATES;
    endfunction

    function automatic void drive_gate(input logic [6:0] note, input logic on);
        logic [7:0] idx;
        idx = {1'b0, note} - NOTE_BASE;   // notes below 60 wrap high
        if (!set_gate_en) return;
        if (idx < set_first_gate || idx >= gate_top()) return;
        if (on) begin
            gate_q[idx]     = 1'b1;
            gate_count[idx] = set_pulse_len;
        end else if (!set_trig_mode) begin
            gate_q[idx]     = 1'b0;
            gate_count[idx] = 8'd0;
        end
    endfunction

    // Apply one word to the predictor, return the levels it leaves behind
    function automatic midi_levels_t step_levels(input logic kind, input logic [3:0] cin,
                                                 input logic [7:0] st, input logic [7:0] d1,
                                                 input logic [7:0] d2);
        midi_levels_t lv;
        logic [6:0]   note;
        note = d1[6:0];
        if (kind) begin
            if (set_clk_en) begin
                if (pulse_count != 0) begin
                    pulse_count = pulse_count - 8'd1;
                    if (pulse_count == 0) clk_out = 1'b0;
                end
                if (silence_count != 0) begin
                    silence_count = silence_count - 16'd1;
                    if (silence_count == 0) clk_count = 6'd1;
                end
            end
            if (set_trig_mode) begin
                for (int i = 0; i < GATES; i++) begin
                    if (i >= set_first_gate && i < gate_top() && gate_count[i] != 0) begin
                        gate_count[i] = gate_count[i] - 8'd1;
                        if (gate_count[i] == 0) gate_q[i] = 1'b0;
                    end
                end
            end
        end else begin
            if (cin == CIN_SINGLE) begin
                if (st == ST_CLOCK) begin
                    silence_count = 16'(NOCLOCK_TICKS);
                    if (clk_running && set_clk_en && clk_count != 0) begin
                        clk_count = clk_count - 6'd1;
                        if (clk_count == 0) begin
                            clk_count   = div_ratio;
                            clk_out     = 1'b1;
                            pulse_count = set_pulse_len;
                        end
                    end
                end else if (st == ST_START || st == ST_CONTINUE) begin
                    if (set_clk_en) begin
                        run_out = 1'b1;
                        if (ss_ctrl) begin
                            clk_running = 1'b1;
                            clk_count   = 6'd1;
                        end
                    end
                end else if (st == ST_STOP) begin
                    if (set_clk_en) begin
                        run_out = 1'b0;
                        if (ss_ctrl) clk_running = 1'b0;
                    end
                end
            end
            // Channel messages only on channel 1
            if (st[3:0] == 4'h0) begin
                if (cin == CIN_NOTE_OFF) begin
                    drive_gate(note, 1'b0);
                end else if (cin == CIN_NOTE_ON) begin
                    drive_gate(note, d2[6:0] != 0);
                end else if (cin == CIN_CTRL) begin
                    if (note == CC_CLOCK_RELOAD) begin
                        if (d2 != 0) load_clock(d2[6:0]);
                    end else if (note == CC_ALL_SOUND_OFF || note == CC_ALL_NOTES_OFF) begin
                        if (set_gate_en) begin
                            for (int i = 0; i < GATES; i++) begin
                                if (i >= set_first_gate && i < gate_top()) begin
                                    gate_q[i]     = 1'b0;
                                    gate_count[i] = 8'd0;
                                end
                            end
                        end
                    end
                end
            end
        end
        lv.gates = gate_q[LEVELS_W-1:0];
        lv.clk   = clk_out;
        lv.run   = run_out;
        return lv;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_NS);
        $display("ERROR: run exceeded its time limit, %0d results still pending",
                 levels_due.size());
        $display("midi_gate_trigger_clock_divider_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern changes at random intervals; a hold-off
    // request from a test keeps m_ready low for the requested time.
    // ------------------------------------------------------------------------
    initial begin : receiver
        rx_mode_t    mode;
        int unsigned slot_left;
        int unsigned hold;
        int unsigned comb_phase;
        m_ready    = 1'b0;
        mode       = RX_OPEN;
        slot_left  = 0;
        comb_phase = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req != 0) begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
                m_ready <= 1'b0;
                repeat (hold - 1) @(negedge aclk);
            end else begin
                if (slot_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    slot_left = $urandom_range(16, 96);
                end
                slot_left--;
                comb_phase++;
                case (mode)
                    RX_OPEN:  m_ready <= 1'b1;
                    RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: m_ready <= ($urandom_range(0, 1) != 0);
                    default:  m_ready <= ((comb_phase % 5) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        midi_levels_t want;
        if (aresetn && m_valid && m_ready) begin
            if (levels_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: result word with nothing pending: gates %h clock %b run %b",
                             m_gate_levels, m_clock_level, m_run_level);
            end else begin
                want = levels_due.pop_front();
                if (m_gate_levels !== want.gates || m_clock_level !== want.clk ||
                    m_run_level !== want.run) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"ERROR: result %0d: gates exp %h got %h, ",
                                  "clock exp %b got %b, run exp %b got %b"},
                                 results_checked, want.gates, m_gate_levels,
                                 want.clk, m_clock_level, want.run, m_run_level);
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drive helpers. Every one starts at a falling edge, assigns its
    // signals there, and returns at a later falling edge.
    // ------------------------------------------------------------------------

    // Offer one word and hold it until accepted; valid stays high on return
    task automatic send_word(input logic kind, input logic [3:0] cin, input logic [7:0] st,
                             input logic [7:0] d1, input logic [7:0] d2);
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_code_index  <= cin;
        s_status_byte <= st;
        s_data_one    <= d1;
        s_data_two    <= d2;
        do @(posedge aclk); while (!s_ready);
        levels_due.push_back(step_levels(kind, cin, st, d1, d2));
        words_sent++;
        if (kind) tick_words++;
        else if (cin == CIN_SINGLE && st == ST_CLOCK) clock_words++;
        else if (cin == CIN_NOTE_ON || cin == CIN_NOTE_OFF) note_words++;
        @(negedge aclk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Stop offering, let every pending result arrive, then settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (levels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register write; the predictor copy follows once the edge has passed
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        case (idx)
            CFG_CLOCK_SETTING:    load_clock(data[6:0]);
            CFG_CLOCK_OUT_ENABLE: set_clk_en     = data[0];
            CFG_GATE_OUT_ENABLE:  set_gate_en    = data[0];
            CFG_TRIGGER_MODE:     set_trig_mode  = data[0];
            CFG_FIRST_GATE:       set_first_gate = data;
            CFG_GATE_LIMIT:       set_gate_limit = data;
            CFG_PULSE_LEN:        set_pulse_len  = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [7:0] cs, input logic [7:0] ce,
                                  input logic [7:0] ge, input logic [7:0] tm,
                                  input logic [7:0] fg, input logic [7:0] gl,
                                  input logic [7:0] tw);
        write_reg(CFG_CLOCK_SETTING, cs);
        write_reg(CFG_CLOCK_OUT_ENABLE, ce);
        write_reg(CFG_GATE_OUT_ENABLE, ge);
        write_reg(CFG_TRIGGER_MODE, tm);
        write_reg(CFG_FIRST_GATE, fg);
        write_reg(CFG_GATE_LIMIT, gl);
        write_reg(CFG_PULSE_LEN, tw);
    endtask

    // Mostly well-formed traffic: ticks, timing clocks, transport, notes
    // near the gate range and controllers; the rest is raw noise.
    task automatic send_random_word();
        int unsigned pick;
        logic [7:0]  r1, r2, r3;
        logic [3:0]  rc;
        logic [6:0]  note;
        logic [7:0]  vel;
        pick = $urandom_range(0, 99);
        r1   = 8'($urandom);
        r2   = 8'($urandom);
        r3   = 8'($urandom);
        rc   = 4'($urandom);
        note = ($urandom_range(0, 4) != 0) ? 7'(NOTE_BASE + $urandom_range(0, 9))
                                           : 7'($urandom_range(0, 127));
        vel  = ($urandom_range(0, 5) == 0) ? {r2[7], 7'd0} : r2;
        if (pick < 30) begin
            send_word(1'b1, rc, r1, r2, r3);
        end else if (pick < 50) begin
            send_word(1'b0, CIN_SINGLE, ST_CLOCK, r2, r3);
        end else if (pick < 56) begin
            case ($urandom_range(0, 2))
                0:       send_word(1'b0, CIN_SINGLE, ST_START, r2, r3);
                1:       send_word(1'b0, CIN_SINGLE, ST_CONTINUE, r2, r3);
                default: send_word(1'b0, CIN_SINGLE, ST_STOP, r2, r3);
            endcase
        end else if (pick < 66) begin
            send_word(1'b0, CIN_NOTE_OFF, ST_NOTE_OFF_CH1, {r1[7], note}, r3);
        end else if (pick < 80) begin
            send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, {r1[7], note}, vel);
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0:       send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, {r1[7], CC_ALL_SOUND_OFF}, r3);
                1:       send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, {r1[7], CC_ALL_NOTES_OFF}, r3);
                2:       send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, {r1[7], CC_CLOCK_RELOAD},
                                   ($urandom_range(0, 3) == 0) ? 8'd0 : r3);
                default: send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, r1, r3);
            endcase
        end else begin
            send_word(r2[0], rc, r1, r2, r3);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: gates at both ends, wrapped and out-of-range notes,
    // velocity masking, channel filter, transport and controllers.
    task automatic test_directed_basics();
        send_word(1'b1, 4'hF, 8'hFF, 8'hFF, 8'hFF);                        // tick
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE, 8'h7F);     // lowest gate
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE + 8'd7, 8'd1);
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE - 8'd1, 8'd64); // wraps
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE + 8'd8, 8'd64); // past limit
        // bit 7 of both data bytes dropped: note 60, velocity zero -> off
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE | 8'h80, 8'h80);
        send_word(1'b0, CIN_NOTE_OFF, ST_NOTE_OFF_CH1, NOTE_BASE + 8'd7, 8'h00);
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1 | 8'h01, NOTE_BASE + 8'd1, 8'd99);
        send_word(1'b0, 4'h0, ST_NOTE_ON_CH1, NOTE_BASE + 8'd1, 8'd99);       // unused CIN
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_START, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_STOP, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CONTINUE, 8'h00, 8'h00);
        send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, CC_CLOCK_RELOAD, 8'h00);      // ignored
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE + 8'd2, 8'd64);
        send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, CC_ALL_SOUND_OFF, 8'h00);
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE + 8'd3, 8'd64);
        send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, CC_ALL_NOTES_OFF, 8'hFF);
        send_word(1'b0, CIN_SINGLE, 8'hFF, 8'hFF, 8'hFF);                   // other status
    endtask

    // Divide ratio zero, start/stop control, zero pulse width, trigger mode
    task automatic test_clock_corner_cases();
        send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, CC_CLOCK_RELOAD, 8'h80);      // ratio zero
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        send_word(1'b0, CIN_CTRL, ST_CTRL_CH1, CC_CLOCK_RELOAD, 8'h42);      // gated, ratio 2
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_START, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        wait_idle();
        write_reg(CFG_PULSE_LEN, 8'd0);
        write_reg(CFG_TRIGGER_MODE, 8'd1);
        write_reg(CFG_UNUSED, 8'hFF);                                      // no register
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        send_word(1'b0, CIN_NOTE_ON, ST_NOTE_ON_CH1, NOTE_BASE + 8'd4, 8'd100);
        send_word(1'b0, CIN_NOTE_OFF, ST_NOTE_OFF_CH1, NOTE_BASE + 8'd4, 8'd0);
        send_word(1'b1, 4'h0, 8'h00, 8'h00, 8'h00);
        send_word(1'b1, 4'h0, 8'h00, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_STOP, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
    endtask

    // Random traffic across fixed corner settings and random settings
    task automatic test_random_phases();
        int unsigned burst;
        logic [7:0]  cs, ce, ge, tm, fg, gl, tw;
        burst = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: apply_settings({1'b0, RST_CLOCK_SETTING}, 8'd1, 8'd1, 8'd0, 8'd0,
                                  RST_GATE_LIMIT, RST_PULSE_LEN);
                1: apply_settings(8'h43, 8'd1, 8'd1, 8'd1, 8'd2, 8'd6, 8'd4);
                2: apply_settings(8'h7F, 8'd1, 8'd1, 8'd0, 8'd0, 8'd255, 8'd255);
                3: apply_settings(8'h00, 8'd0, 8'd0, 8'd1, 8'd0, 8'd8, 8'd1);
                4: apply_settings(8'h40, 8'd1, 8'd1, 8'd1, 8'd255, 8'd0, 8'd0);
                default: begin
                    // upper data bits random: single-bit registers must mask them
                    cs = 8'($urandom);
                    ce = 8'($urandom);
                    ce[0] = ($urandom_range(0, 3) != 0);
                    ge = 8'($urandom);
                    ge[0] = ($urandom_range(0, 3) != 0);
                    tm = 8'($urandom);
                    fg = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                    gl = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(4, 9)) : 8'($urandom);
                    tw = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 12))
                                                     : 8'($urandom);
                    apply_settings(cs, ce, ge, tm, fg, gl, tw);
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (burst == 0) begin
                    burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 12);
                    if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
                end
                send_random_word();
                burst--;
            end
        end
    endtask

    // Receiver holds off long enough for both internal registers to fill
    // and s_ready to drop while the sender keeps offering words.
    task automatic test_backpressure();
        wait_idle();
        rx_hold_req = 80;
        repeat (30) send_random_word();
    endtask

    // Silence timeout restarts a divider stuck at ratio zero; the
    // countdown pauses while clock handling is off.
    task automatic test_silence_timeout();
        wait_idle();
        apply_settings(8'h40, 8'd1, 8'd1, 8'd0, 8'd0, RST_GATE_LIMIT, 8'd3);
        send_word(1'b0, CIN_SINGLE, ST_START, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);     // stuck at zero
        repeat (600) send_word(1'b1, 4'h0, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(CFG_CLOCK_OUT_ENABLE, 8'd0);
        repeat (100) send_word(1'b1, 4'h0, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(CFG_CLOCK_OUT_ENABLE, 8'd1);
        // remaining countdown; the last tick restarts the divider
        repeat (NOCLOCK_TICKS - 600) send_word(1'b1, 4'h0, 8'h00, 8'h00, 8'h00);
        send_word(1'b0, CIN_SINGLE, ST_CLOCK, 8'h00, 8'h00);     // restarted
        repeat (4) send_word(1'b1, 4'h0, 8'h00, 8'h00, 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_CLOCK_SETTING;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_kind        = 1'b0;
        s_code_index  = '0;
        s_status_byte = '0;
        s_data_one    = '0;
        s_data_two    = '0;

        // predictor at reset
        set_clk_en     = 1'b1;
        set_gate_en    = 1'b1;
        set_trig_mode  = 1'b0;
        set_first_gate = 8'd0;
        set_gate_limit = RST_GATE_LIMIT;
        set_pulse_len  = RST_PULSE_LEN;
        load_clock(RST_CLOCK_SETTING);
        clk_count     = 6'd1;
        pulse_count   = 8'd0;
        silence_count = 16'(NOCLOCK_TICKS);
        clk_out       = 1'b0;
        run_out       = 1'b0;
        gate_q        = '0;
        for (int i = 0; i < GATES; i++) gate_count[i] = 8'd0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_basics();
        test_clock_corner_cases();
        test_random_phases();
        test_backpressure();
        test_silence_timeout();
        wait_idle();

        $display("Summary: %0d words sent (%0d ticks, %0d timing clocks, %0d note events), %0d %s",
                 words_sent, tick_words, clock_words, note_words, reg_writes,
                 "register writes over default, corner and random settings.");
        $display("Summary: %0d result words compared under stalls and hold-off, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0) begin
            $display("midi_gate_trigger_clock_divider_top test passed");
        end else begin
            $display("midi_gate_trigger_clock_divider_top test failed");
        end
        $finish;
    end

endmodule
